// ===== rtl/core/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and fixed widths shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

    // Number formats of the datapath.
    localparam int ELEM_W  = 16;  // Q8.8 input element
    localparam int PROD_W  = 32;  // product of two elements
    localparam int COF_W   = 33;  // signed 2x2 cofactor, Q16.16
    localparam int CMAG_W  = 32;  // cofactor magnitude
    localparam int DET_W   = 49;  // signed determinant, Q24.24
    localparam int DMAG_W  = 48;  // determinant magnitude
    localparam int INV_W   = 32;  // Q16.16 inverse element
    localparam int QUO_W   = 33;  // quotient bits kept by the divider

    // Numerator is the cofactor magnitude shifted left by this amount.
    localparam int FRAC_SHIFT = 24;

    // One quotient bit per divider stage, plus the range-check stage.
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_DEPTH = DIV_STEPS + 1;

    // Lanes: one per cofactor.
    localparam int LANES = 9;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [CMAG_W-1:0]        cmag_t;
    typedef logic [DMAG_W-1:0]        dmag_t;
    typedef logic [QUO_W-1:0]         quo_t;
    typedef logic signed [INV_W-1:0]  inv_t;

    // Result of one divider lane.
    typedef struct packed {
        quo_t quo;
        logic ovf;
    } div_res_t;

    localparam inv_t INV_MAX = {1'b0, {(INV_W-1){1'b1}}};
    localparam inv_t INV_MIN = {1'b1, {(INV_W-1){1'b0}}};

endpackage

// ===== rtl/core/mi3_divider.sv =====
// ----------------------------------------------------------------------------
// mi3_divider
// Pipelined restoring divider for one lane: (cof_mag << 24) / det_mag,
// one quotient bit per stage, with a flag when the quotient needs more
// than 33 bits.
// ----------------------------------------------------------------------------
module mi3_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  mi3_pkg::cmag_t cof_mag,
    input  mi3_pkg::dmag_t det_mag,
    output mi3_pkg::div_res_t res
);
    import mi3_pkg::*;

    dmag_t rem_reg [0:DIV_STEPS];
    dmag_t den_reg [0:DIV_STEPS];
    cmag_t num_reg [0:DIV_STEPS];
    quo_t  quo_reg [0:DIV_STEPS];
    logic  ovf_reg [0:DIV_STEPS];

    // Range-check stage: the top numerator bits must be below the divisor.
    dmag_t rem0_next;
    logic  ovf0_next;

    assign rem0_next = {{(DMAG_W-CMAG_W+QUO_W-FRAC_SHIFT){1'b0}},
                        cof_mag[CMAG_W-1:QUO_W-FRAC_SHIFT]};
    assign ovf0_next = (rem0_next >= det_mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem0_next;
            den_reg[0] <= det_mag;
            num_reg[0] <= cof_mag;
            quo_reg[0] <= '0;
            ovf_reg[0] <= ovf0_next;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        localparam int BIT = DIV_STEPS - k;
        logic                num_bit;
        logic [DMAG_W:0]     trial;
        logic [DMAG_W:0]     diff;
        dmag_t               rem_next;
        quo_t                quo_next;

        if (BIT >= FRAC_SHIFT)
        begin : g_nbit
            assign num_bit = num_reg[k-1][BIT-FRAC_SHIFT];
        end
        else
        begin : g_zbit
            assign num_bit = 1'b0;
        end

        always_comb
        begin
            trial = {rem_reg[k-1], num_bit};
            diff  = trial - {1'b0, den_reg[k-1]};
            if (trial >= {1'b0, den_reg[k-1]})
            begin
                rem_next = diff[DMAG_W-1:0];
                quo_next = {quo_reg[k-1][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DMAG_W-1:0];
                quo_next = {quo_reg[k-1][QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_reg[k-1];
                num_reg[k] <= num_reg[k-1];
                quo_reg[k] <= quo_next;
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign res.quo = quo_reg[DIV_STEPS];
    assign res.ovf = ovf_reg[DIV_STEPS];

    // The remainder of the last stage is not needed; keep it visible to lint.
    logic unused_rem;
    assign unused_rem = ^rem_reg[DIV_STEPS] ^ ^den_reg[DIV_STEPS] ^ ^num_reg[DIV_STEPS]
                        ^ rst_n;

endmodule

// ===== rtl/core/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a 3x3 Q8.8 matrix by the adjugate method, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel carries the nine elements a11..a33. It is
// taken when in_valid and in_ready are both high. The result channel returns
// the nine Q16.16 inverse elements, the exact Q24.24 determinant and the
// singular flag, one result per request, in request order.
// The pipeline has 40 register stages: five for the products, cofactors,
// determinant and magnitudes, 34 divider stages (a range check, then one
// quotient bit per stage) and one output stage. out_valid is the valid bit
// of the output stage and holds until taken. Without a stall, throughput is
// one matrix per cycle; a new request can enter every cycle.
// The whole pipeline advances on one enable; when the receiver holds
// out_ready low with a result waiting, every stage holds and in_ready falls,
// so nothing is lost or repeated. Empty stages never block.
// Reset clears all valid bits; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mi3_pkg::elem_t  a11,
    input  mi3_pkg::elem_t  a12,
    input  mi3_pkg::elem_t  a13,
    input  mi3_pkg::elem_t  a21,
    input  mi3_pkg::elem_t  a22,
    input  mi3_pkg::elem_t  a23,
    input  mi3_pkg::elem_t  a31,
    input  mi3_pkg::elem_t  a32,
    input  mi3_pkg::elem_t  a33,
    output logic            out_valid,
    input  logic            out_ready,
    output mi3_pkg::inv_t   inv11,
    output mi3_pkg::inv_t   inv12,
    output mi3_pkg::inv_t   inv13,
    output mi3_pkg::inv_t   inv21,
    output mi3_pkg::inv_t   inv22,
    output mi3_pkg::inv_t   inv23,
    output mi3_pkg::inv_t   inv31,
    output mi3_pkg::inv_t   inv32,
    output mi3_pkg::inv_t   inv33,
    output mi3_pkg::det_t   det_value,
    output logic            singular
);
    import mi3_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic dv_reg [0:DIV_STEPS];

    // The pipeline moves unless a finished result is held by the receiver.
    assign en       = !vo_reg || out_ready;
    assign in_ready = en;

    // Operand pairs of the cofactors: cof[k] = pa_x*pa_y - pb_x*pb_y.
    elem_t pa_x [0:LANES-1];
    elem_t pa_y [0:LANES-1];
    elem_t pb_x [0:LANES-1];
    elem_t pb_y [0:LANES-1];

    always_comb
    begin
        pa_x[0] = a22; pa_y[0] = a33; pb_x[0] = a23; pb_y[0] = a32;
        pa_x[1] = a23; pa_y[1] = a31; pb_x[1] = a21; pb_y[1] = a33;
        pa_x[2] = a21; pa_y[2] = a32; pb_x[2] = a22; pb_y[2] = a31;
        pa_x[3] = a13; pa_y[3] = a32; pb_x[3] = a12; pb_y[3] = a33;
        pa_x[4] = a11; pa_y[4] = a33; pb_x[4] = a13; pb_y[4] = a31;
        pa_x[5] = a12; pa_y[5] = a31; pb_x[5] = a11; pb_y[5] = a32;
        pa_x[6] = a12; pa_y[6] = a23; pb_x[6] = a13; pb_y[6] = a22;
        pa_x[7] = a13; pa_y[7] = a21; pb_x[7] = a11; pb_y[7] = a23;
        pa_x[8] = a11; pa_y[8] = a22; pb_x[8] = a12; pb_y[8] = a21;
    end

    // Stage 1: element products.
    prod_t pa_reg [0:LANES-1];
    prod_t pb_reg [0:LANES-1];
    elem_t r1_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                pa_reg[k] <= pa_x[k] * pa_y[k];
                pb_reg[k] <= pb_x[k] * pb_y[k];
            end
            r1_reg[0] <= a11;
            r1_reg[1] <= a12;
            r1_reg[2] <= a13;
        end
    end

    // Stage 2: signed cofactors.
    cof_t  cof2_reg [0:LANES-1];
    elem_t r2_reg   [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                cof2_reg[k] <= COF_W'(pa_reg[k]) - COF_W'(pb_reg[k]);
            end
            for (int j = 0; j < 3; j++)
            begin
                r2_reg[j] <= r1_reg[j];
            end
        end
    end

    // Stage 3: first-row terms of the determinant, cofactor magnitudes.
    det_t  term_reg [0:2];
    cmag_t cmag3_reg [0:LANES-1];
    logic  cneg3_reg [0:LANES-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                term_reg[j] <= DET_W'(r2_reg[j]) * DET_W'(cof2_reg[j]);
            end
            for (int k = 0; k < LANES; k++)
            begin
                cmag3_reg[k] <= cof2_reg[k][COF_W-1] ? CMAG_W'(-cof2_reg[k])
                                                     : CMAG_W'(cof2_reg[k]);
                cneg3_reg[k] <= cof2_reg[k][COF_W-1];
            end
        end
    end

    // Stage 4: determinant sum.
    det_t  det4_reg;
    cmag_t cmag4_reg [0:LANES-1];
    logic  cneg4_reg [0:LANES-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det4_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            for (int k = 0; k < LANES; k++)
            begin
                cmag4_reg[k] <= cmag3_reg[k];
                cneg4_reg[k] <= cneg3_reg[k];
            end
        end
    end

    // Stage 5: determinant magnitude, result signs and zero check.
    det_t  det5_reg;
    dmag_t dmag5_reg;
    logic  dzero5_reg;
    cmag_t cmag5_reg [0:LANES-1];
    logic  neg5_reg  [0:LANES-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det5_reg   <= det4_reg;
            dmag5_reg  <= det4_reg[DET_W-1] ? DMAG_W'(-det4_reg) : DMAG_W'(det4_reg);
            dzero5_reg <= (det4_reg == '0);
            for (int k = 0; k < LANES; k++)
            begin
                cmag5_reg[k] <= cmag4_reg[k];
                neg5_reg[k]  <= cneg4_reg[k] ^ det4_reg[DET_W-1];
            end
        end
    end

    // Divider lanes, one per cofactor.
    div_res_t dres [0:LANES-1];

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        mi3_divider u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .cof_mag (cmag5_reg[k]),
            .det_mag (dmag5_reg),
            .res     (dres[k])
        );
    end

    // Side information that travels beside the divider stages.
    det_t dd_reg    [0:DIV_STEPS];
    logic dz_reg    [0:DIV_STEPS];
    logic dneg_reg  [0:DIV_STEPS][0:LANES-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0] <= det5_reg;
            dz_reg[0] <= dzero5_reg;
            for (int k = 0; k < LANES; k++)
            begin
                dneg_reg[0][k] <= neg5_reg[k];
            end
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                dd_reg[s] <= dd_reg[s-1];
                dz_reg[s] <= dz_reg[s-1];
                for (int k = 0; k < LANES; k++)
                begin
                    dneg_reg[s][k] <= dneg_reg[s-1][k];
                end
            end
        end
    end

    // Sign, saturation and the singular case.
    inv_t inv_next [0:LANES-1];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (dz_reg[DIV_STEPS])
            begin
                inv_next[k] = '0;
            end
            else if (dneg_reg[DIV_STEPS][k])
            begin
                if (dres[k].ovf || dres[k].quo[QUO_W-1] || dres[k].quo[QUO_W-2])
                    inv_next[k] = INV_MIN;
                else
                    inv_next[k] = -inv_t'(dres[k].quo[INV_W-1:0]);
            end
            else
            begin
                if (dres[k].ovf || dres[k].quo[QUO_W-1] || dres[k].quo[QUO_W-2])
                    inv_next[k] = INV_MAX;
                else
                    inv_next[k] = inv_t'(dres[k].quo[INV_W-1:0]);
            end
        end
    end

    // Output register.
    inv_t out_inv_reg [0:LANES-1];
    det_t out_det_reg;
    logic out_sing_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                out_inv_reg[k] <= inv_next[k];
            end
            out_det_reg  <= dd_reg[DIV_STEPS];
            out_sing_reg <= dz_reg[DIV_STEPS];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                dv_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                dv_reg[s] <= dv_reg[s-1];
            end
            vo_reg <= dv_reg[DIV_STEPS];
        end
    end

    // Inverse element (r, c) is cofactor (c, r) over the determinant.
    assign inv11     = out_inv_reg[0];
    assign inv12     = out_inv_reg[3];
    assign inv13     = out_inv_reg[6];
    assign inv21     = out_inv_reg[1];
    assign inv22     = out_inv_reg[4];
    assign inv23     = out_inv_reg[7];
    assign inv31     = out_inv_reg[2];
    assign inv32     = out_inv_reg[5];
    assign inv33     = out_inv_reg[8];
    assign det_value = out_det_reg;
    assign singular  = out_sing_reg;
    assign out_valid = vo_reg;

endmodule
